@@ rtl/gbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_pkg
// shared types and constants of the generational buffer pool
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_BYTES = 64;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int BYTE_W     = $clog2(SLOT_BYTES);
    localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
    localparam int HW_W       = $clog2(NUM_SLOTS + 1);
    localparam int MEM_DEPTH  = NUM_SLOTS * SLOT_BYTES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_SUM    = 3'd2;
    localparam logic [2:0] CMD_MOVE   = 3'd3;
    localparam logic [2:0] CMD_FREE   = 3'd4;
    localparam logic [2:0] CMD_REPORT = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_STALE    = 3'd1;
    localparam logic [2:0] ST_BOUNDS   = 3'd2;
    localparam logic [2:0] ST_SAME     = 3'd3;
    localparam logic [2:0] ST_NO_FREE  = 3'd4;
    localparam logic [2:0] ST_TOO_BIG  = 3'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  alloc_size;
        logic [7:0]  slot_index;
        logic [15:0] slot_gen;
        logic [7:0]  byte_offset;
        logic [7:0]  byte_value;
        logic [7:0]  dest_index;
        logic [15:0] dest_gen;
    } gbp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  handle_index;
        logic [15:0] handle_gen;
        logic [13:0] result_value;
        logic [4:0]  live_slots;
        logic [10:0] live_bytes;
    } gbp_out_t;

    // byte memory access request
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } gbp_mem_req_t;

endpackage

`default_nettype wire

@@ rtl/gbp_byte_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_byte_ram
// byte storage of all slots, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gbp_byte_ram
    import gbp_pkg::*;
(
    input  wire logic         clk,
    input  wire gbp_mem_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

@@ rtl/generational_buffer_pool.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// generational_buffer_pool
// pool of byte buffers addressed by slot index and generation handles
//
//   channel  signals              direction  handshake
//   command  start, busy, cmd_in  in         taken when start & !busy
//   result   done, rsp_out        out        one-cycle strobe on done
//
// slot tables (mark, generation, length) sit in registers; bytes in one RAM.
// set, free, errors and zero-length items finish from the execute state; report
// walks all NUM_SLOTS slots; allocate zero-fills one byte per cycle; sum reads
// one byte per cycle; move copies one byte per cycle from source to destination.
// the single RAM port pair sets these rates. reset clears the tables at once.
// results cannot be stalled: done pulses once per item.
// ----------------------------------------------------------------------------
module generational_buffer_pool
    import gbp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire gbp_in_t  cmd_in,
    output logic          busy,
    output logic          done,
    output gbp_out_t      rsp_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_REPT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    gbp_in_t           in_reg;
    gbp_out_t          rsp_reg, rsp_next;
    logic              done_reg, done_next;
    logic [NUM_SLOTS-1:0] occ_reg, occ_next;
    logic [15:0]       gen_reg [NUM_SLOTS];
    logic [LEN_W-1:0]  len_reg [NUM_SLOTS];
    logic [HW_W-1:0]   hw_reg, hw_next;
    logic              gen_we, len_we;
    logic [SLOT_W-1:0] tbl_idx;
    logic [15:0]       gen_wdata;
    logic [LEN_W-1:0]  len_wdata;
    logic              len_clr_we;
    logic [SLOT_W-1:0] len_clr_idx;

    // walk state
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  lim_reg, lim_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] dslot_reg, dslot_next;
    logic [LEN_W-1:0]  dbase_reg, dbase_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  pcnt_reg, pcnt_next;
    logic [13:0]       acc_reg, acc_next;
    logic [4:0]        ls_reg, ls_next;
    logic [10:0]       lb_reg, lb_next;

    gbp_mem_req_t      mreq;
    logic [7:0]        rdata;

    gbp_byte_ram u_ram
    (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    function automatic logic live(input logic [7:0] idx, input logic [15:0] g,
                                  input logic [NUM_SLOTS-1:0] occ,
                                  input logic [HW_W-1:0] hw,
                                  input logic [15:0] gv);
        logic r;
        r = ({1'b0, idx} < 9'(hw)) && (idx < 8'(NUM_SLOTS)) && occ[idx[SLOT_W-1:0]]
            && (gv == g);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                 input logic [LEN_W-1:0] o);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ADDR_W'(s) * ADDR_W'(SLOT_BYTES)) + ADDR_W'(o);
        return a;
    endfunction

    logic [SLOT_W-1:0] si, di;
    logic              s_live, d_live;
    logic [SLOT_W-1:0] free_idx;
    logic              free_found;

    always_comb
    begin
        si = in_reg.slot_index[SLOT_W-1:0];
        di = in_reg.dest_index[SLOT_W-1:0];
        s_live = live(in_reg.slot_index, in_reg.slot_gen, occ_reg, hw_reg, gen_reg[si]);
        d_live = live(in_reg.dest_index, in_reg.dest_gen, occ_reg, hw_reg, gen_reg[di]);
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if ((HW_W'(k) < hw_reg) && !occ_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        occ_next    = occ_reg;
        hw_next     = hw_reg;
        gen_we      = 1'b0;
        len_we      = 1'b0;
        tbl_idx     = si;
        gen_wdata   = '0;
        len_wdata   = '0;
        len_clr_we  = 1'b0;
        len_clr_idx = si;
        cnt_next    = cnt_reg;
        lim_next    = lim_reg;
        slot_next   = slot_reg;
        dslot_next  = dslot_reg;
        dbase_next  = dbase_reg;
        pend_next   = 1'b0;
        pcnt_next   = cnt_reg;
        acc_next    = acc_reg;
        ls_next     = ls_reg;
        lb_next     = lb_reg;
        mreq        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rsp_next   = '0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                cnt_next   = '0;
                acc_next   = '0;
                unique case (in_reg.cmd)
                    CMD_ALLOC:
                    begin
                        if (in_reg.alloc_size > 8'(SLOT_BYTES))
                        begin
                            rsp_next.status = ST_TOO_BIG;
                        end
                        else if (!free_found && (hw_reg >= HW_W'(NUM_SLOTS)))
                        begin
                            rsp_next.status = ST_NO_FREE;
                        end
                        else
                        begin
                            tbl_idx = free_found ? free_idx : hw_reg[SLOT_W-1:0];
                            if (!free_found)
                            begin
                                hw_next = hw_reg + 1'b1;
                            end
                            occ_next[tbl_idx] = 1'b1;
                            gen_we    = 1'b1;
                            gen_wdata = gen_reg[tbl_idx] + 16'd1;
                            len_we    = 1'b1;
                            len_wdata = LEN_W'(in_reg.alloc_size);
                            rsp_next.handle_index = 4'(tbl_idx);
                            rsp_next.handle_gen   = gen_wdata;
                            slot_next = tbl_idx;
                            lim_next  = LEN_W'(in_reg.alloc_size);
                            if (in_reg.alloc_size != 8'd0)
                            begin
                                done_next  = 1'b0;
                                state_next = S_FILL;
                            end
                        end
                    end
                    CMD_SET:
                    begin
                        if (!s_live)
                        begin
                            rsp_next.status = ST_STALE;
                        end
                        else if ({1'b0, in_reg.byte_offset} >= 9'(len_reg[si]))
                        begin
                            rsp_next.status = ST_BOUNDS;
                        end
                        else
                        begin
                            mreq.wr    = 1'b1;
                            mreq.waddr = addr_of(si, LEN_W'(in_reg.byte_offset));
                            mreq.wdata = in_reg.byte_value;
                        end
                    end
                    CMD_SUM:
                    begin
                        if (!s_live)
                        begin
                            rsp_next.status = ST_STALE;
                        end
                        else if (len_reg[si] != '0)
                        begin
                            slot_next  = si;
                            lim_next   = len_reg[si];
                            done_next  = 1'b0;
                            state_next = S_READ;
                        end
                    end
                    CMD_MOVE:
                    begin
                        if (!s_live || !d_live)
                        begin
                            rsp_next.status = ST_STALE;
                        end
                        else if (si == di)
                        begin
                            rsp_next.status = ST_SAME;
                        end
                        else if (9'(len_reg[si]) + 9'(len_reg[di]) > 9'(SLOT_BYTES))
                        begin
                            rsp_next.status = ST_TOO_BIG;
                        end
                        else
                        begin
                            tbl_idx   = di;
                            len_we    = 1'b1;
                            len_wdata = len_reg[si] + len_reg[di];
                            len_clr_we = 1'b1;
                            occ_next[si] = 1'b0;
                            rsp_next.result_value = 14'(len_wdata);
                            slot_next  = si;
                            dslot_next = di;
                            dbase_next = len_reg[di];
                            lim_next   = len_reg[si];
                            if (len_reg[si] != '0)
                            begin
                                done_next  = 1'b0;
                                state_next = S_READ;
                            end
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!s_live)
                        begin
                            rsp_next.status = ST_STALE;
                        end
                        else
                        begin
                            occ_next[si] = 1'b0;
                            len_clr_we   = 1'b1;
                        end
                    end
                    CMD_REPORT:
                    begin
                        slot_next  = '0;
                        ls_next    = '0;
                        lb_next    = '0;
                        done_next  = 1'b0;
                        state_next = S_REPT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FILL:
            begin
                mreq.wr    = 1'b1;
                mreq.waddr = addr_of(slot_reg, cnt_reg);
                mreq.wdata = 8'd0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_next == lim_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                // read one byte per cycle, consume it the next cycle
                if (cnt_reg != lim_reg)
                begin
                    mreq.raddr = addr_of(slot_reg, cnt_reg);
                    pend_next  = 1'b1;
                    pcnt_next  = cnt_reg;
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (in_reg.cmd == CMD_SUM)
                    begin
                        acc_next = acc_reg + 14'(rdata);
                    end
                    else
                    begin
                        mreq.wr    = 1'b1;
                        mreq.waddr = addr_of(dslot_reg, dbase_reg + pcnt_reg);
                        mreq.wdata = rdata;
                    end
                end
                if (!pend_next && pend_reg)
                begin
                    if (in_reg.cmd == CMD_SUM)
                    begin
                        rsp_next.result_value = acc_next;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPT:
            begin
                if ((HW_W'(slot_reg) < hw_reg) && occ_reg[slot_reg])
                begin
                    ls_next = ls_reg + 5'd1;
                    lb_next = lb_reg + 11'(len_reg[slot_reg]);
                end
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(NUM_SLOTS - 1))
                begin
                    rsp_next.live_slots = ls_next;
                    rsp_next.live_bytes = lb_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            occ_reg   <= '0;
            hw_reg    <= '0;
            pend_reg  <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                gen_reg[k] <= '0;
                len_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            occ_reg   <= occ_next;
            hw_reg    <= hw_next;
            pend_reg  <= pend_next;
            if (gen_we)
            begin
                gen_reg[tbl_idx] <= gen_wdata;
            end
            if (len_clr_we)
            begin
                len_reg[len_clr_idx] <= '0;
            end
            if (len_we)
            begin
                len_reg[tbl_idx] <= len_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            in_reg <= cmd_in;
        end
        rsp_reg   <= rsp_next;
        cnt_reg   <= cnt_next;
        lim_reg   <= lim_next;
        slot_reg  <= slot_next;
        dslot_reg <= dslot_next;
        dbase_reg <= dbase_next;
        pcnt_reg  <= pcnt_next;
        acc_reg   <= acc_next;
        ls_reg    <= ls_next;
        lb_reg    <= lb_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign rsp_out = rsp_reg;

endmodule

`default_nettype wire
